// File: rtl/nearest_point_search_2d_macros.svh
// ----------------------------------------------------------------------------
// Nearest point search macros
// Assertion wrappers used by the nearest point search top level. Defining
// ASSERT_OFF turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_2D_MACROS_SVH
`define NEAREST_POINT_SEARCH_2D_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds whenever the antecedent holds.
`define NPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nearest point search: implication check failed");

// Checks that a condition never holds outside reset.
`define NPSD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("nearest point search: forbidden condition seen");

`else

`define NPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPSD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/npsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search package
// Shared constants, operation codes and types of the 2D nearest point search.
// ----------------------------------------------------------------------------
package npsd_pkg;

	// Table geometry.
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Field widths.
	localparam int COORD_W = 32;
	localparam int ID_W    = 32;
	localparam int DELTA_W = COORD_W + 1;
	localparam int MAG_W   = COORD_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int DIST_W  = SQ_W + 1;
	localparam int QIDX_W  = 20;
	localparam int OP_W    = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// One stored reference point.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [ID_W-1:0]           id;
	} point_t;

	// One scored candidate leaving the distance pipeline.
	typedef struct packed {
		logic                      valid;
		logic                      last;
		logic [ADDR_W-1:0]         index;
		logic [ID_W-1:0]           id;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [DIST_W-1:0]         sq_dist;
	} cand_t;

endpackage

// File: rtl/npsd_dist_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search distance pipeline
// Turns one reference point per cycle into its deltas against the query and
// its exact squared Euclidean distance, over four register stages.
// ----------------------------------------------------------------------------
module npsd_dist_pipe (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_s1,
	input  logic                                   last_s1,
	input  logic [npsd_pkg::ADDR_W-1:0]            index_s1,
	input  npsd_pkg::point_t                       point_s1,
	input  logic signed [npsd_pkg::COORD_W-1:0]    query_x,
	input  logic signed [npsd_pkg::COORD_W-1:0]    query_y,
	output npsd_pkg::cand_t                        cand
);
	import npsd_pkg::*;

	// Stage 2: signed deltas, reference minus query.
	logic                      valid_s2, last_s2;
	logic [ADDR_W-1:0]         index_s2;
	logic [ID_W-1:0]           id_s2;
	logic signed [DELTA_W-1:0] dx_s2, dy_s2;

	// Stage 3: magnitudes of the deltas.
	logic                      valid_s3, last_s3;
	logic [ADDR_W-1:0]         index_s3;
	logic [ID_W-1:0]           id_s3;
	logic signed [DELTA_W-1:0] dx_s3, dy_s3;
	logic [MAG_W-1:0]          mx_s3, my_s3;

	// Stage 4: squares.
	logic                      valid_s4, last_s4;
	logic [ADDR_W-1:0]         index_s4;
	logic [ID_W-1:0]           id_s4;
	logic signed [DELTA_W-1:0] dx_s4, dy_s4;
	logic [SQ_W-1:0]           sx_s4, sy_s4;

	// Stage 5: distance sum.
	logic                      valid_s5, last_s5;
	logic [ADDR_W-1:0]         index_s5;
	logic [ID_W-1:0]           id_s5;
	logic signed [DELTA_W-1:0] dx_s5, dy_s5;
	logic [DIST_W-1:0]         dist_s5;

	logic [DELTA_W-1:0] neg_dx, neg_dy;

	assign neg_dx = -dx_s2;
	assign neg_dy = -dy_s2;

	// Valid and last flags travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		last_s2  <= last_s1;
		index_s2 <= index_s1;
		id_s2    <= point_s1.id;
		dx_s2    <= DELTA_W'(point_s1.x) - DELTA_W'(query_x);
		dy_s2    <= DELTA_W'(point_s1.y) - DELTA_W'(query_y);

		last_s3  <= last_s2;
		index_s3 <= index_s2;
		id_s3    <= id_s2;
		dx_s3    <= dx_s2;
		dy_s3    <= dy_s2;
		mx_s3    <= dx_s2[DELTA_W-1] ? neg_dx[MAG_W-1:0] : dx_s2[MAG_W-1:0];
		my_s3    <= dy_s2[DELTA_W-1] ? neg_dy[MAG_W-1:0] : dy_s2[MAG_W-1:0];

		last_s4  <= last_s3;
		index_s4 <= index_s3;
		id_s4    <= id_s3;
		dx_s4    <= dx_s3;
		dy_s4    <= dy_s3;
		sx_s4    <= SQ_W'(mx_s3) * SQ_W'(mx_s3);
		sy_s4    <= SQ_W'(my_s3) * SQ_W'(my_s3);

		last_s5  <= last_s4;
		index_s5 <= index_s4;
		id_s5    <= id_s4;
		dx_s5    <= dx_s4;
		dy_s5    <= dy_s4;
		dist_s5  <= DIST_W'(sx_s4) + DIST_W'(sy_s4);
	end

	assign cand.valid   = valid_s5;
	assign cand.last    = last_s5;
	assign cand.index   = index_s5;
	assign cand.id      = id_s5;
	assign cand.dx      = dx_s5;
	assign cand.dy      = dy_s5;
	assign cand.sq_dist = dist_s5;

endmodule

// File: rtl/nearest_point_search_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search in two dimensions
// Brute-force nearest neighbor search over a table of reference points held
// in one synchronous memory, scored by exact squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries clear, load and query
// transactions; one output channel (out_valid/out_ready) returns one result
// for every load and every query, none for clear or the unused code.
// A clear or load completes at the accepting edge, where the load result is
// registered. A query on a table of N points streams the memory one
// entry per cycle through a five-stage read and distance pipeline; the
// single memory read port sets that rate.
// A query on an empty table answers at once with found low.
// The block works on one transaction at a time: in_ready is high only while
// no scan runs and the output register is free or being emptied. When the
// receiver stalls, the finished result waits in the output register.
// After reset the table is empty and the query count is zero; the memory
// contents are not cleared, since only entries below the fill count are read.
// ----------------------------------------------------------------------------
`include "nearest_point_search_2d_macros.svh"

module nearest_point_search_2d (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [npsd_pkg::OP_W-1:0]            operation,
	input  logic signed [npsd_pkg::COORD_W-1:0]  x_position,
	input  logic signed [npsd_pkg::COORD_W-1:0]  y_position,
	input  logic [npsd_pkg::ID_W-1:0]            point_id,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [npsd_pkg::QIDX_W-1:0]          query_index,
	output logic [npsd_pkg::ID_W-1:0]            query_id,
	output logic [npsd_pkg::ADDR_W-1:0]          nearest_index,
	output logic [npsd_pkg::ID_W-1:0]            nearest_id,
	output logic signed [npsd_pkg::DELTA_W-1:0]  delta_x,
	output logic signed [npsd_pkg::DELTA_W-1:0]  delta_y,
	output logic                                 found,
	output logic                                 overflow
);
	import npsd_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [QIDX_W-1:0]       qcount_q;
	logic [CNT_W-1:0]        scan_q;
	logic                    table_full;
	logic                    in_fire, out_slot_free;
	logic                    is_load, is_query, is_clear;
	logic                    rd_en, rd_last;

	// Query held for the duration of a scan.
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic [ID_W-1:0]           qid_q;
	logic [QIDX_W-1:0]         qidx_q;

	// Memory and its registered read port.
	point_t                  mem [MAX_POINTS];
	point_t                  point_s1;
	logic                    valid_s1, last_s1;
	logic [ADDR_W-1:0]       index_s1;

	// Best candidate so far.
	cand_t                   cand;
	logic                    best_have_q;
	logic [ADDR_W-1:0]       best_index_q;
	logic [ID_W-1:0]         best_id_q;
	logic signed [DELTA_W-1:0] best_dx_q, best_dy_q;
	logic [DIST_W-1:0]       best_dist_q;
	logic                    take_cand;

	// Output register.
	logic                    out_valid_q;

	assign out_slot_free = !out_valid_q || out_ready;
	assign in_ready      = (state_q == ST_IDLE) && out_slot_free;
	assign in_fire       = in_valid && in_ready;
	assign is_clear      = (operation == OP_CLEAR);
	assign is_load       = (operation == OP_LOAD);
	assign is_query      = (operation == OP_QUERY);
	assign table_full    = (count_q == CNT_W'(MAX_POINTS));
	assign rd_en         = (state_q == ST_SCAN);
	assign rd_last       = (scan_q == count_q - CNT_W'(1));

	// Sequencer, fill count, query count and scan address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			qcount_q <= '0;
			scan_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (is_clear) begin
							count_q  <= '0;
							qcount_q <= '0;
						end else if (is_load) begin
							if (!table_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (is_query) begin
							qcount_q <= qcount_q + QIDX_W'(1);
							scan_q   <= '0;
							if (count_q != '0) begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (rd_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cand.valid && cand.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query capture at acceptance.
	always_ff @(posedge clk) begin
		if (in_fire && is_query) begin
			qx_q   <= x_position;
			qy_q   <= y_position;
			qid_q  <= point_id;
			qidx_q <= qcount_q;
		end
	end

	// Point table: appended on load, streamed on query.
	always_ff @(posedge clk) begin
		if (in_fire && is_load && !table_full) begin
			mem[count_q[ADDR_W-1:0]] <= '{x: x_position, y: y_position, id: point_id};
		end
		if (rd_en) begin
			point_s1 <= mem[scan_q[ADDR_W-1:0]];
		end
	end

	// Read stage tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= rd_last;
		index_s1 <= scan_q[ADDR_W-1:0];
	end

	npsd_dist_pipe u_dist_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.last_s1  (last_s1),
		.index_s1 (index_s1),
		.point_s1 (point_s1),
		.query_x  (qx_q),
		.query_y  (qy_q),
		.cand     (cand)
	);

	// Strictly smaller distance wins, so the earliest point keeps a tie.
	assign take_cand = cand.valid && (!best_have_q || (cand.sq_dist < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_have_q <= 1'b0;
		end else if (in_fire && is_query) begin
			best_have_q <= 1'b0;
		end else if (cand.valid) begin
			best_have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_cand) begin
			best_index_q <= cand.index;
			best_id_q    <= cand.id;
			best_dx_q    <= cand.dx;
			best_dy_q    <= cand.dy;
			best_dist_q  <= cand.sq_dist;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && (is_load || (is_query && count_q == '0))) begin
			out_valid_q <= 1'b1;
		end else if ((state_q == ST_DONE) && out_slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_fire && (is_load || is_query)) begin
			query_index   <= is_query ? qcount_q : '0;
			query_id      <= is_query ? point_id : '0;
			nearest_index <= '0;
			nearest_id    <= '0;
			delta_x       <= '0;
			delta_y       <= '0;
			found         <= 1'b0;
			overflow      <= is_load && table_full;
		end else if ((state_q == ST_DONE) && out_slot_free) begin
			query_index   <= qidx_q;
			query_id      <= qid_q;
			nearest_index <= best_index_q;
			nearest_id    <= best_id_q;
			delta_x       <= best_dx_q;
			delta_y       <= best_dy_q;
			found         <= 1'b1;
			overflow      <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Design checks.
	`NPSD_ASSERT_NEVER(a_count_in_range, clk, arst_n, count_q > CNT_W'(MAX_POINTS))
	`NPSD_ASSERT_IMPL(a_cand_only_in_scan, clk, arst_n, cand.valid,
		(state_q == ST_SCAN) || (state_q == ST_DRAIN))
	`NPSD_ASSERT_IMPL(a_found_index_stored, clk, arst_n, out_valid_q && found,
		CNT_W'(nearest_index) < count_q)
	`NPSD_ASSERT_IMPL(a_overflow_when_full, clk, arst_n, out_valid_q && overflow,
		table_full)

endmodule

// File: tb/tb_nearest_point_search_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search testbench
// Drives clear, load and query transactions with random stalls on both
// channels. Each accepted transaction updates a local copy of the point table,
// which computes the exact 65-bit nearest match. Every returned result is
// then compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_nearest_point_search_2d;
	import npsd_pkg::*;

	// Unused operation code; the block must ignore it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 580;
	localparam int STALL_LIMIT  = 6000;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ID_W-1:0]    id;
		bit                 hold;
	} point_txn_t;

	typedef struct packed {
		logic [QIDX_W-1:0]         query_index;
		logic [ID_W-1:0]           query_id;
		logic [ADDR_W-1:0]         nearest_index;
		logic [ID_W-1:0]           nearest_id;
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic                      found;
		logic                      overflow;
	} search_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [OP_W-1:0]            operation = '0;
	logic signed [COORD_W-1:0]  x_position = '0;
	logic signed [COORD_W-1:0]  y_position = '0;
	logic [ID_W-1:0]            point_id = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [QIDX_W-1:0]          query_index;
	logic [ID_W-1:0]            query_id;
	logic [ADDR_W-1:0]          nearest_index;
	logic [ID_W-1:0]            nearest_id;
	logic signed [DELTA_W-1:0]  delta_x;
	logic signed [DELTA_W-1:0]  delta_y;
	logic                       found;
	logic                       overflow;

	// Pending stimulus and pending predictions.
	point_txn_t     point_stream[$];
	search_result_t awaited_results[$];
	point_txn_t     on_bus;
	bit             bus_taken = 1'b0;
	int             gap_left = 0;
	int             stall_left = 0;
	bit             in_calm = 1'b0;
	bit             out_calm = 1'b0;

	// Local copy of the point table.
	logic signed [COORD_W-1:0] tbl_x [MAX_POINTS];
	logic signed [COORD_W-1:0] tbl_y [MAX_POINTS];
	logic [ID_W-1:0]           tbl_id [MAX_POINTS];
	int                        tbl_count = 0;
	logic [QIDX_W-1:0]         query_count = '0;

	// Generator bookkeeping and run statistics.
	int gen_items = 0;
	int gen_fill = 0;
	int n_errors = 0;
	int n_checked = 0;
	int n_loads = 0;
	int n_dropped = 0;
	int n_queries = 0;
	int n_empty = 0;
	int n_clears = 0;
	int n_ignored = 0;
	int idle_cycles = 0;

	nearest_point_search_2d DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.x_position(x_position),
		.y_position(y_position),
		.point_id(point_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.query_index(query_index),
		.query_id(query_id),
		.nearest_index(nearest_index),
		.nearest_id(nearest_id),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.found(found),
		.overflow(overflow)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Coordinate near a cluster center, at an extreme, or anywhere.
	function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] center);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return $urandom;
		if (r < 25) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				3: return 32'h0000_0001;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r < 65) return center + COORD_W'(int'($urandom_range(0, 16)) - 8);
		return center + COORD_W'(int'($urandom_range(0, 4096)) - 2048);
	endfunction

	task automatic push_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [ID_W-1:0] id, input bit hold);
		point_txn_t t;
		t.op = op;
		t.x = x;
		t.y = y;
		t.id = id;
		t.hold = hold;
		point_stream = {point_stream, t};
		if (op != OP_UNUSED) gen_items++;
		if (op == OP_CLEAR) gen_fill = 0;
		else if (op == OP_LOAD) gen_fill++;
	endtask

	// Applies one accepted transaction to the local table and queues the result
	// it must produce. The nearest point is the strictly smallest exact squared
	// distance, so the earliest stored point wins a tie.
	task automatic predict_nearest(input point_txn_t t);
		search_result_t            r;
		logic signed [DELTA_W-1:0] dx, dy, best_dx, best_dy;
		logic [DELTA_W-1:0]        mag_x, mag_y;
		logic [DIST_W-1:0]         sq_dist, best_dist;
		int                        i, best;
		r = '0;
		best = -1;
		best_dist = '0;
		best_dx = '0;
		best_dy = '0;
		case (t.op)
			OP_CLEAR: begin
				tbl_count = 0;
				query_count = '0;
				n_clears++;
			end
			OP_LOAD: begin
				n_loads++;
				if (tbl_count < MAX_POINTS) begin
					tbl_x[tbl_count] = t.x;
					tbl_y[tbl_count] = t.y;
					tbl_id[tbl_count] = t.id;
					tbl_count++;
				end else begin
					r.overflow = 1'b1;
					n_dropped++;
				end
				awaited_results = {awaited_results, r};
			end
			OP_QUERY: begin
				n_queries++;
				r.query_index = query_count;
				r.query_id = t.id;
				query_count++;
				for (i = 0; i < tbl_count; i++) begin
					dx = {tbl_x[i][COORD_W-1], tbl_x[i]} - {t.x[COORD_W-1], t.x};
					dy = {tbl_y[i][COORD_W-1], tbl_y[i]} - {t.y[COORD_W-1], t.y};
					mag_x = dx[DELTA_W-1] ? -dx : dx;
					mag_y = dy[DELTA_W-1] ? -dy : dy;
					sq_dist = DIST_W'(mag_x) * DIST_W'(mag_x)
						+ DIST_W'(mag_y) * DIST_W'(mag_y);
					if (best < 0 || sq_dist < best_dist) begin
						best = i;
						best_dist = sq_dist;
						best_dx = dx;
						best_dy = dy;
					end
				end
				if (best >= 0) begin
					r.nearest_index = ADDR_W'(best);
					r.nearest_id = tbl_id[best];
					r.delta_x = best_dx;
					r.delta_y = best_dy;
					r.found = 1'b1;
				end else begin
					n_empty++;
				end
				awaited_results = {awaited_results, r};
			end
			default: begin
				n_ignored++;
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [DELTA_W-1:0] want,
			input logic [DELTA_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
			n_errors++;
		end
	endtask

	// Driver: presents the next pending transaction at the falling edge, after
	// a random gap, or after the result queue drains when the item asks for it.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if ($urandom_range(0, 299) == 0) in_calm = !in_calm;
			if (!in_valid || bus_taken) begin
				bus_taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (point_stream.size() != 0 &&
						!(point_stream[0].hold && awaited_results.size() != 0)) begin
					on_bus = point_stream.pop_front();
					operation <= on_bus.op;
					x_position <= on_bus.x;
					y_position <= on_bus.y;
					point_id <= on_bus.id;
					in_valid <= 1'b1;
					gap_left = in_calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver backpressure, with calm stretches of constant ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// Monitor: predicts on each input transaction and checks each result.
	always @(posedge clk) begin
		search_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_nearest(on_bus);
				bus_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result with no prediction pending: query_id 0x%h", query_id);
					n_errors++;
				end else begin
					want = awaited_results.pop_front();
					n_checked++;
					compare_field("query_index", DELTA_W'(want.query_index),
						DELTA_W'(query_index));
					compare_field("query_id", DELTA_W'(want.query_id), DELTA_W'(query_id));
					compare_field("nearest_index", DELTA_W'(want.nearest_index),
						DELTA_W'(nearest_index));
					compare_field("nearest_id", DELTA_W'(want.nearest_id),
						DELTA_W'(nearest_id));
					compare_field("delta_x", want.delta_x, delta_x);
					compare_field("delta_y", want.delta_y, delta_y);
					compare_field("found", DELTA_W'(want.found), DELTA_W'(found));
					compare_field("overflow", DELTA_W'(want.overflow), DELTA_W'(overflow));
				end
			end
		end
	end

	// Watchdog on cycles without any transaction on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$error("no transaction for %0d cycles", idle_cycles);
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	initial begin
		int                 k, n, m;
		logic [COORD_W-1:0] cx, cy, lx, ly;
		lx = '0;
		ly = '0;

		// Directed: empty table, ignored code, extreme coordinates, a distance
		// that needs the 65th bit, exact ties, and counter restart after clear.
		push_item(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		push_item(OP_UNUSED, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h1234_5678, 1'b0);
		push_item(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
		push_item(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		push_item(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b0);
		push_item(OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'hA5A5_A5A5, 1'b0);
		push_item(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h0000_0002, 1'b0);
		push_item(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0);
		push_item(OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0003, 1'b0);
		push_item(OP_QUERY, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0004, 1'b0);
		push_item(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
		push_item(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0);
		push_item(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		push_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_item(OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'hDEAD_0001, 1'b0);
		push_item(OP_LOAD, 32'h0000_0001, 32'h0000_0000, 32'h0000_0010, 1'b0);
		push_item(OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0020, 1'b0);
		push_item(OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'hDEAD_0002, 1'b0);
		push_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_item(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'hDEAD_0003, 1'b0);

		// Random episodes: usually a clear, a cluster of loads, then queries near it,
		// with ignored codes, early queries and stray clears mixed in.
		gen_items = 0;
		while (gen_items < RANDOM_ITEMS) begin
			cx = $urandom;
			cy = $urandom;
			if (gen_fill > 160 || $urandom_range(0, 99) < 65)
				push_item(OP_CLEAR, $urandom, $urandom, $urandom, ($urandom_range(0, 19) == 0));
			if ($urandom_range(0, 99) < 8)
				push_item(OP_QUERY, pick_coord(cx), pick_coord(cy), $urandom, 1'b0);
			n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 96);
			for (k = 0; k < n; k++) begin
				m = $urandom_range(0, 99);
				if (m < 3) push_item(OP_UNUSED, $urandom, $urandom, $urandom, 1'b0);
				else if (m < 5) push_item(OP_QUERY, pick_coord(cx), pick_coord(cy), $urandom, 1'b0);
				// Repeating the previous point creates exact ties.
				if (k == 0 || $urandom_range(0, 7) != 0) begin
					lx = pick_coord(cx);
					ly = pick_coord(cy);
				end
				push_item(OP_LOAD, lx, ly, $urandom, ($urandom_range(0, 59) == 0));
			end
			m = $urandom_range(1, 6);
			for (k = 0; k < m; k++)
				push_item(OP_QUERY, pick_coord(cx), pick_coord(cy), $urandom,
						($urandom_range(0, 59) == 0));
			if ($urandom_range(0, 99) < 4)
				push_item(OP_CLEAR, $urandom, $urandom, $urandom, 1'b0);
		end

		// Reset, then run until every transaction is sent and answered.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (point_stream.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("Run covered %0d loads (%0d dropped at capacity), %0d queries",
				n_loads, n_dropped, n_queries);
		$display("(%0d on an empty table), %0d clears, %0d ignored codes; %0d results checked.",
				n_empty, n_clears, n_ignored, n_checked);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/npsd_pkg.sv
rtl/npsd_dist_pipe.sv
rtl/nearest_point_search_2d.sv
tb/tb_nearest_point_search_2d.sv
